@@ sv/fjpt_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjpt_pkg: shared types and constants of the flat JSON pair tokenizer
// Beat types of both channels, the queue entry, character codes and pair types.
// ---------------------------------------------------------------------------
package fjpt_pkg;

	localparam int unsigned MAX_PAIRS_DEF   = 32;
	localparam int unsigned KEY_BYTES_DEF   = 64;
	localparam int unsigned VALUE_BYTES_DEF = 512;
	localparam int unsigned QUEUE_DEPTH     = 4;

	// character codes
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COMMA  = 8'h2c;
	localparam logic [7:0] CH_MINUS  = 8'h2d;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_COLON  = 8'h3a;
	localparam logic [7:0] CH_A      = 8'h61;
	localparam logic [7:0] CH_E      = 8'h65;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_L      = 8'h6c;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;

	// pair types
	localparam logic [1:0] TYPE_STRING = 2'd0;
	localparam logic [1:0] TYPE_NUMBER = 2'd1;
	localparam logic [1:0] TYPE_BOOL   = 2'd2;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_mark;
	} text_t;

	typedef struct packed {
		logic       key_char_valid;
		logic       value_char_valid;
		logic [7:0] char_out;
		logic       pair_end;
		logic [1:0] pair_type;
		logic [4:0] pair_index;
		logic       parse_end;
		logic       parse_ok;
		logic [5:0] pair_total;
	} token_t;

	// character classes found by the front end
	typedef struct packed {
		logic blank;
		logic sp_tab;
		logic quote;
		logic colon;
		logic comma;
		logic lbrace;
		logic rbrace;
		logic num;
		logic lit_t;
		logic lit_f;
	} char_class_t;

	typedef struct packed {
		text_t       text;
		char_class_t cls;
	} entry_t;

	// expected character of the true / false literal at a position
	function automatic logic [7:0] lit_char(input logic is_false, input logic [2:0] pos);
		logic [7:0] c;
		c = CH_E;
		if (is_false) begin
			case (pos)
				3'd0:    c = CH_F;
				3'd1:    c = CH_A;
				3'd2:    c = CH_L;
				3'd3:    c = CH_S;
				default: c = CH_E;
			endcase
		end else begin
			case (pos)
				3'd0:    c = CH_T;
				3'd1:    c = CH_R;
				3'd2:    c = CH_U;
				default: c = CH_E;
			endcase
		end
		return c;
	endfunction

endpackage

@@ sv/fjpt_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjpt_front: input stage of the tokenizer
// Accepts text beats, classifies the character and registers it for the queue.
// ---------------------------------------------------------------------------
module fjpt_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            text_valid,
	output logic            text_stall,
	input  fjpt_pkg::text_t text_data,
	input  logic            queue_full,
	output logic            push,
	output fjpt_pkg::entry_t push_entry
);
	import fjpt_pkg::*;

	logic        valid_s1;
	entry_t      entry_s1;
	char_class_t cls;
	logic        accept;

	// classify the incoming character
	always_comb begin
		cls        = '0;
		cls.blank  = text_data.in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
		cls.sp_tab = text_data.in_byte inside {CH_SPACE, CH_TAB};
		cls.quote  = (text_data.in_byte == CH_QUOTE);
		cls.colon  = (text_data.in_byte == CH_COLON);
		cls.comma  = (text_data.in_byte == CH_COMMA);
		cls.lbrace = (text_data.in_byte == CH_LBRACE);
		cls.rbrace = (text_data.in_byte == CH_RBRACE);
		cls.num    = text_data.in_byte inside {[CH_ZERO:CH_NINE], CH_MINUS, CH_DOT};
		cls.lit_t  = (text_data.in_byte == CH_T);
		cls.lit_f  = (text_data.in_byte == CH_F);
	end

	// hold the stage while the queue is full
	assign push       = valid_s1 && !queue_full;
	assign text_stall = valid_s1 && queue_full;
	assign accept     = text_valid && !text_stall;
	assign push_entry = entry_s1;

	// advance the stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry_s1.text <= text_data;
			entry_s1.cls  <= cls;
		end
	end

endmodule

@@ sv/fjpt_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjpt_queue: short queue between front end and parser
// Holds classified characters so either side can stall on its own.
// ---------------------------------------------------------------------------
module fjpt_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fjpt_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             avail,
	output fjpt_pkg::entry_t head
);
	import fjpt_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             store_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign avail = (count_q != '0);
	assign head  = store_q[rd_ptr_q];

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// write the entry
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

@@ sv/fjpt_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fjpt_back: pair parser of the tokenizer
// Walks the JSON object one character per cycle unless stalled and registers the token beats.
// ---------------------------------------------------------------------------
module fjpt_back #(
	parameter int unsigned MAX_PAIRS   = fjpt_pkg::MAX_PAIRS_DEF,
	parameter int unsigned KEY_BYTES   = fjpt_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_BYTES = fjpt_pkg::VALUE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             avail,
	input  fjpt_pkg::entry_t head,
	output logic             pop,
	output logic             token_valid,
	input  logic             token_stall,
	output fjpt_pkg::token_t token_data
);
	import fjpt_pkg::*;

	localparam int unsigned PW_RAW = $clog2(MAX_PAIRS + 1);
	localparam int unsigned PW     = (PW_RAW < 6) ? 6 : PW_RAW;
	localparam int unsigned KW     = $clog2(KEY_BYTES);
	localparam int unsigned VW     = $clog2(VALUE_BYTES);

	localparam logic [3:0] PH_LEAD      = 4'd0;
	localparam logic [3:0] PH_BETWEEN   = 4'd1;
	localparam logic [3:0] PH_KEY       = 4'd2;
	localparam logic [3:0] PH_COLON     = 4'd3;
	localparam logic [3:0] PH_PREVAL    = 4'd4;
	localparam logic [3:0] PH_STRING    = 4'd5;
	localparam logic [3:0] PH_NUMBER    = 4'd6;
	localparam logic [3:0] PH_LITERAL   = 4'd7;
	localparam logic [3:0] PH_SKIPDELIM = 4'd8;
	localparam logic [3:0] PH_DONE      = 4'd9;

	logic [3:0]    phase_q, phase_nxt;
	logic [KW-1:0] key_len_q, key_len_nxt;
	logic [VW-1:0] val_len_q, val_len_nxt;
	logic [PW-1:0] pairs_q, pairs_nxt;
	logic [2:0]    lit_pos_q, lit_pos_nxt;
	logic          lit_false_q, lit_false_nxt;

	logic          valid_q;
	token_t        token_q;
	token_t        res;
	logic          has_res;

	logic [PW-1:0] pairs_inc;
	logic          limit_hit;
	logic [KW:0]   key_inc;
	logic [VW:0]   val_inc;
	logic [VW-1:0] val_base;
	logic [2:0]    lit_pos_inc;
	logic [2:0]    lit_len;
	logic [3:0]    skip_phase;
	logic [3:0]    between_phase;
	logic          fin;
	logic [1:0]    fin_type;
	logic [7:0]    b;
	char_class_t   cls;

	assign b   = head.text.in_byte;
	assign cls = head.cls;

	// take a character when the result register is free or being drained
	assign pop         = avail && (!valid_q || !token_stall);
	assign token_valid = valid_q;
	assign token_data  = token_q;

	// shared counters and follow-on phases
	always_comb begin
		pairs_inc   = pairs_q + 1'b1;
		limit_hit   = (pairs_inc >= PW'(MAX_PAIRS));
		key_inc     = {1'b0, key_len_q} + 1'b1;
		val_base    = (phase_q == PH_PREVAL) ? '0 : val_len_q;
		val_inc     = {1'b0, val_base} + 1'b1;
		lit_pos_inc = lit_pos_q + 1'b1;
		lit_len     = lit_false_q ? 3'd5 : 3'd4;
		if (cls.comma) begin
			skip_phase = PH_BETWEEN;
		end else if (cls.rbrace) begin
			skip_phase = PH_DONE;
		end else begin
			skip_phase = PH_SKIPDELIM;
		end
		if (cls.blank || cls.comma) begin
			between_phase = PH_BETWEEN;
		end else if (cls.quote) begin
			between_phase = PH_KEY;
		end else begin
			between_phase = PH_DONE;
		end
	end

	// parse one character
	always_comb begin
		phase_nxt     = phase_q;
		key_len_nxt   = key_len_q;
		val_len_nxt   = val_len_q;
		lit_pos_nxt   = lit_pos_q;
		lit_false_nxt = lit_false_q;
		res           = '0;
		fin           = 1'b0;
		fin_type      = TYPE_STRING;

		if (head.text.end_mark) begin
			// close the text, recording a pair that was begun
			case (phase_q)
				PH_KEY, PH_COLON, PH_PREVAL, PH_NUMBER: begin
					fin      = 1'b1;
					fin_type = TYPE_NUMBER;
				end
				PH_STRING: begin
					fin      = 1'b1;
					fin_type = TYPE_STRING;
				end
				PH_LITERAL: begin
					fin      = 1'b1;
					fin_type = TYPE_BOOL;
				end
				default: begin
					fin = 1'b0;
				end
			endcase
			res.parse_end = 1'b1;
			res.parse_ok  = fin || (pairs_q != '0);
			phase_nxt     = PH_LEAD;
			key_len_nxt   = '0;
			val_len_nxt   = '0;
			lit_pos_nxt   = '0;
			lit_false_nxt = 1'b0;
		end else begin
			case (phase_q)
				PH_LEAD: begin
					if (!(cls.blank || cls.lbrace)) begin
						phase_nxt = between_phase;
						if (cls.quote) begin
							key_len_nxt = '0;
						end
					end
				end
				PH_BETWEEN: begin
					phase_nxt = between_phase;
					if (cls.quote) begin
						key_len_nxt = '0;
					end
				end
				PH_KEY: begin
					if (cls.quote) begin
						phase_nxt = PH_COLON;
					end else begin
						res.key_char_valid = 1'b1;
						res.char_out       = b;
						key_len_nxt        = key_inc[KW-1:0];
						if (key_inc >= (KW+1)'(KEY_BYTES - 1)) begin
							phase_nxt = PH_COLON;
						end
					end
				end
				PH_COLON: begin
					if (cls.colon) begin
						phase_nxt = PH_PREVAL;
					end
				end
				PH_PREVAL, PH_NUMBER: begin
					if (phase_q == PH_PREVAL && cls.sp_tab) begin
						phase_nxt = PH_PREVAL;
					end else if (phase_q == PH_PREVAL && cls.quote) begin
						phase_nxt   = PH_STRING;
						val_len_nxt = '0;
					end else if (phase_q == PH_PREVAL && (cls.lit_t || cls.lit_f)) begin
						phase_nxt     = PH_LITERAL;
						lit_false_nxt = cls.lit_f;
						lit_pos_nxt   = 3'd1;
					end else if (cls.num) begin
						// number character: emit, end at the length limit
						phase_nxt            = PH_NUMBER;
						res.value_char_valid = 1'b1;
						res.char_out         = b;
						val_len_nxt          = val_inc[VW-1:0];
						if (val_inc >= (VW+1)'(VALUE_BYTES - 1)) begin
							fin       = 1'b1;
							fin_type  = TYPE_NUMBER;
							phase_nxt = limit_hit ? PH_DONE : PH_SKIPDELIM;
						end
					end else begin
						// end of number; the byte takes part in the delimiter skip
						fin         = 1'b1;
						fin_type    = TYPE_NUMBER;
						val_len_nxt = val_base;
						phase_nxt   = limit_hit ? PH_DONE : skip_phase;
					end
				end
				PH_STRING: begin
					if (cls.quote) begin
						fin       = 1'b1;
						fin_type  = TYPE_STRING;
						phase_nxt = limit_hit ? PH_DONE : PH_SKIPDELIM;
					end else begin
						res.value_char_valid = 1'b1;
						res.char_out         = b;
						val_len_nxt          = val_inc[VW-1:0];
						if (val_inc >= (VW+1)'(VALUE_BYTES - 1)) begin
							fin       = 1'b1;
							fin_type  = TYPE_STRING;
							phase_nxt = limit_hit ? PH_DONE : PH_SKIPDELIM;
						end
					end
				end
				PH_LITERAL: begin
					fin_type = TYPE_BOOL;
					if (b == lit_char(lit_false_q, lit_pos_q)) begin
						lit_pos_nxt = lit_pos_inc;
						if (lit_pos_inc >= lit_len) begin
							res.value_char_valid = 1'b1;
							res.char_out         = lit_false_q ? CH_ZERO : CH_ONE;
							fin                  = 1'b1;
							phase_nxt            = limit_hit ? PH_DONE : PH_SKIPDELIM;
						end
					end else begin
						// unmatched literal gives an empty boolean
						fin       = 1'b1;
						phase_nxt = limit_hit ? PH_DONE : skip_phase;
					end
				end
				PH_SKIPDELIM: begin
					phase_nxt = skip_phase;
				end
				default: begin
					phase_nxt = PH_DONE;
				end
			endcase
		end

		pairs_nxt      = fin ? pairs_inc : pairs_q;
		res.pair_end   = fin;
		res.pair_type  = fin ? fin_type : TYPE_STRING;
		res.pair_index = pairs_q[4:0];
		res.pair_total = pairs_nxt[5:0];
		has_res        = head.text.end_mark || res.key_char_valid || res.value_char_valid || fin;
		if (head.text.end_mark) begin
			pairs_nxt = '0;
		end
	end

	// update parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			key_len_q   <= '0;
			val_len_q   <= '0;
			pairs_q     <= '0;
			lit_pos_q   <= '0;
			lit_false_q <= 1'b0;
		end else if (pop) begin
			phase_q     <= phase_nxt;
			key_len_q   <= key_len_nxt;
			val_len_q   <= val_len_nxt;
			pairs_q     <= pairs_nxt;
			lit_pos_q   <= lit_pos_nxt;
			lit_false_q <= lit_false_nxt;
		end
	end

	// hold the result beat until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop && has_res) begin
			valid_q <= 1'b1;
		end else if (!token_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && has_res) begin
			token_q <= res;
		end
	end

endmodule

@@ sv/flat_json_pair_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// flat_json_pair_tokenizer_unit: flat JSON object tokenizer
// Streams key and value characters, pair ends with type and index, and an
// end beat with the parse status.
// ---------------------------------------------------------------------------
// Channel | Direction | Beat
// text    | sink      | one character of the object, or the end mark
// token   | source    | key or value character, pair end, and/or parse end
//
// Sustains one text beat per cycle while the token channel does not stall; each beat gives zero or one token beat.
// A beat passes through the front register, the queue and the result register.
// The parser state machine sets the rate, handling one character per cycle while the token channel does not stall.
// Reset returns the parser to the leading blank skip; the end beat does too.
// A token stall fills the four-entry queue, then the text channel stalls.
// ---------------------------------------------------------------------------
module flat_json_pair_tokenizer_unit #(
	parameter int unsigned MAX_PAIRS   = fjpt_pkg::MAX_PAIRS_DEF,
	parameter int unsigned KEY_BYTES   = fjpt_pkg::KEY_BYTES_DEF,
	parameter int unsigned VALUE_BYTES = fjpt_pkg::VALUE_BYTES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             text_valid,
	output logic             text_stall,
	input  fjpt_pkg::text_t  text_data,
	output logic             token_valid,
	input  logic             token_stall,
	output fjpt_pkg::token_t token_data
);
	import fjpt_pkg::*;

	logic   push;
	entry_t push_entry;
	logic   queue_full;
	logic   pop;
	logic   avail;
	entry_t head;

	fjpt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_stall (text_stall),
		.text_data  (text_data),
		.queue_full (queue_full),
		.push       (push),
		.push_entry (push_entry)
	);

	fjpt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (queue_full),
		.pop        (pop),
		.avail      (avail),
		.head       (head)
	);

	fjpt_back #(
		.MAX_PAIRS   (MAX_PAIRS),
		.KEY_BYTES   (KEY_BYTES),
		.VALUE_BYTES (VALUE_BYTES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.avail       (avail),
		.head        (head),
		.pop         (pop),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench: flat JSON pair tokenizer unit
// Drives JSON text beats through the tokenizer and checks every token beat
// against a directed table or a cycle-free parser model kept in step with the
// accepted text, under several patterns of sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
	import fjpt_pkg::*;

	localparam int unsigned RANDOM_BEATS = 1200;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned DRAIN_CYCLES = 10;
	localparam int unsigned MAX_REPORTS  = 40;

	localparam logic [31:0] WORD_TRUE  = {CH_T, CH_R, CH_U, CH_E};
	localparam logic [39:0] WORD_FALSE = {CH_F, CH_A, CH_L, CH_S, CH_E};

	typedef enum logic [3:0] {
		P_LEAD, P_BETWEEN, P_KEY, P_COLON, P_PREVAL,
		P_STRING, P_NUMBER, P_LITERAL, P_SKIP, P_DONE
	} parse_phase_t;

	typedef struct packed {
		text_t  beat;
		logic   typed;
		token_t tok;
	} stim_row_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   text_valid = 1'b0;
	logic   text_stall;
	text_t  text_data = '0;
	logic   token_valid;
	logic   token_stall = 1'b0;
	token_t token_data;

	// parser model state
	parse_phase_t ph;
	logic [5:0]   key_len;
	logic [8:0]   val_len;
	logic [5:0]   pair_count;
	logic [2:0]   lit_pos;
	logic         lit_false;

	token_t      pending_tokens [$];
	text_t       obj_beats [$];
	stim_row_t   dir_rows [$];
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned beats_sent = 0;
	int unsigned tokens_seen = 0;
	int unsigned pair_ends_seen = 0;
	int unsigned texts_closed = 0;

	flat_json_pair_tokenizer_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_valid  (text_valid),
		.text_stall  (text_stall),
		.text_data   (text_data),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_data  (token_data)
	);

	always #5 clk = ~clk;

	// ---------------- parser model ----------------

	function automatic bit blank_char(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
	endfunction

	function automatic bit num_char(input logic [7:0] b);
		return (b >= CH_ZERO && b <= CH_NINE) || b == CH_MINUS || b == CH_DOT;
	endfunction

	task automatic parser_clear();
		ph = P_LEAD;
		key_len = '0;
		val_len = '0;
		pair_count = '0;
		lit_pos = '0;
		lit_false = 1'b0;
	endtask

	task automatic close_pair(input logic [1:0] ty, inout token_t r);
		r.pair_end = 1'b1;
		r.pair_type = ty;
		r.pair_index = pair_count[4:0];
		pair_count = pair_count + 1'b1;
	endtask

	task automatic skip_step(input logic [7:0] b);
		if (b == CH_COMMA) ph = P_BETWEEN;
		else if (b == CH_RBRACE) ph = P_DONE;
		else ph = P_SKIP;
	endtask

	task automatic between_step(input logic [7:0] b);
		if (blank_char(b) || b == CH_COMMA) begin
			ph = P_BETWEEN;
		end else if (b == CH_QUOTE) begin
			ph = P_KEY;
			key_len = '0;
		end else begin
			ph = P_DONE;
		end
	endtask

	// stop at the pair limit, else look for the next delimiter
	task automatic after_pair(input logic [7:0] b, input bit used);
		if (pair_count >= MAX_PAIRS_DEF) ph = P_DONE;
		else if (used) ph = P_SKIP;
		else skip_step(b);
	endtask

	task automatic number_step(input logic [7:0] b, inout token_t r);
		if (num_char(b)) begin
			r.value_char_valid = 1'b1;
			r.char_out = b;
			val_len = val_len + 1'b1;
			if (val_len >= VALUE_BYTES_DEF - 1) begin
				close_pair(TYPE_NUMBER, r);
				after_pair(b, 1'b1);
			end
		end else begin
			close_pair(TYPE_NUMBER, r);
			after_pair(b, 1'b0);
		end
	endtask

	task automatic parser_step(input text_t t, output bit has, output token_t r);
		logic [7:0] b;
		logic [7:0] want;
		logic [2:0] lit_len;
		logic [2:0] pos;
		b = t.in_byte;
		r = '0;
		r.pair_index = pair_count[4:0];
		has = 1'b0;
		if (t.end_mark) begin
			// close any pair in flight, then report and start over
			case (ph)
				P_KEY, P_COLON, P_PREVAL, P_NUMBER: close_pair(TYPE_NUMBER, r);
				P_STRING: close_pair(TYPE_STRING, r);
				P_LITERAL: close_pair(TYPE_BOOL, r);
				default: ;
			endcase
			r.parse_end = 1'b1;
			r.parse_ok = pair_count != 0;
			r.pair_total = pair_count;
			parser_clear();
			has = 1'b1;
		end else begin
			case (ph)
				P_LEAD: begin
					if (!(blank_char(b) || b == CH_LBRACE)) between_step(b);
				end
				P_BETWEEN: between_step(b);
				P_KEY: begin
					if (b == CH_QUOTE) begin
						ph = P_COLON;
					end else begin
						r.key_char_valid = 1'b1;
						r.char_out = b;
						key_len = key_len + 1'b1;
						if (key_len >= KEY_BYTES_DEF - 1) ph = P_COLON;
					end
				end
				P_COLON: begin
					if (b == CH_COLON) ph = P_PREVAL;
				end
				P_PREVAL: begin
					if (b == CH_SPACE || b == CH_TAB) begin
						ph = P_PREVAL;
					end else if (b == CH_QUOTE) begin
						ph = P_STRING;
						val_len = '0;
					end else if (b == CH_T || b == CH_F) begin
						ph = P_LITERAL;
						lit_false = b == CH_F;
						lit_pos = 3'd1;
					end else begin
						ph = P_NUMBER;
						val_len = '0;
						number_step(b, r);
					end
				end
				P_STRING: begin
					if (b == CH_QUOTE) begin
						close_pair(TYPE_STRING, r);
						after_pair(b, 1'b1);
					end else begin
						r.value_char_valid = 1'b1;
						r.char_out = b;
						val_len = val_len + 1'b1;
						if (val_len >= VALUE_BYTES_DEF - 1) begin
							close_pair(TYPE_STRING, r);
							after_pair(b, 1'b1);
						end
					end
				end
				P_NUMBER: number_step(b, r);
				P_LITERAL: begin
					// a mismatch ends the pair as an empty boolean
					lit_len = lit_false ? 3'd5 : 3'd4;
					pos = lit_pos < lit_len ? lit_pos : lit_len - 3'd1;
					want = lit_false ? WORD_FALSE[8 * (4 - pos) +: 8]
						: WORD_TRUE[8 * (3 - pos) +: 8];
					if (b == want) begin
						lit_pos = pos + 3'd1;
						if (lit_pos >= lit_len) begin
							r.value_char_valid = 1'b1;
							r.char_out = lit_false ? CH_ZERO : CH_ONE;
							close_pair(TYPE_BOOL, r);
							after_pair(b, 1'b1);
						end
					end else begin
						close_pair(TYPE_BOOL, r);
						after_pair(b, 1'b0);
					end
				end
				P_SKIP: skip_step(b);
				default: ph = P_DONE;
			endcase
			has = r.key_char_valid | r.value_char_valid | r.pair_end;
			if (has) r.pair_total = pair_count;
		end
	endtask

	// ---------------- stimulus helpers ----------------

	function automatic token_t tok_of(input logic kcv, input logic vcv, input logic [7:0] ch,
			input logic pe, input logic [1:0] ty, input logic [4:0] idx, input logic pend,
			input logic pok, input logic [5:0] tot);
		token_t r;
		r.key_char_valid = kcv;
		r.value_char_valid = vcv;
		r.char_out = ch;
		r.pair_end = pe;
		r.pair_type = ty;
		r.pair_index = idx;
		r.parse_end = pend;
		r.parse_ok = pok;
		r.pair_total = tot;
		return r;
	endfunction

	function automatic stim_row_t drow(input logic [7:0] ch, input logic endm, input logic typed,
			input token_t tok);
		stim_row_t s;
		s.beat = {ch, endm};
		s.typed = typed;
		s.tok = tok;
		return s;
	endfunction

	function automatic logic [7:0] text_char();
		logic [7:0] c;
		do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
		return c;
	endfunction

	function automatic logic [7:0] number_char();
		int unsigned k;
		k = $urandom_range(11);
		if (k == 10) return CH_MINUS;
		if (k == 11) return CH_DOT;
		return 8'(CH_ZERO + k);
	endfunction

	task automatic push_ch(input logic [7:0] b);
		obj_beats.push_back({b, 1'b0});
	endtask

	task automatic add_blanks(input bit sp_tab);
		int unsigned n;
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) begin
			if (sp_tab) begin
				push_ch($urandom_range(1) ? CH_SPACE : CH_TAB);
			end else begin
				case ($urandom_range(3))
					0: push_ch(CH_SPACE);
					1: push_ch(CH_TAB);
					2: push_ch(CH_LF);
					default: push_ch(CH_CR);
				endcase
			end
		end
	endtask

	// value kinds: string, number, true, false, broken literal, any start byte
	task automatic add_value(input int unsigned kind, input int unsigned len);
		int unsigned n;
		logic        is_f;
		case (kind)
			0: begin
				push_ch(CH_QUOTE);
				repeat (len) push_ch(text_char());
				push_ch(CH_QUOTE);
			end
			2: for (int i = 3; i >= 0; i--) push_ch(WORD_TRUE[8 * i +: 8]);
			3: for (int i = 4; i >= 0; i--) push_ch(WORD_FALSE[8 * i +: 8]);
			4: begin
				is_f = 1'($urandom_range(1));
				n = $urandom_range(1, is_f ? 4 : 3);
				for (int i = 0; i < n; i++) begin
					push_ch(is_f ? WORD_FALSE[8 * (4 - i) +: 8]
						: WORD_TRUE[8 * (3 - i) +: 8]);
				end
				push_ch(8'($urandom_range(255)));
			end
			5: push_ch(8'($urandom_range(255)));
			default: repeat (len) push_ch(number_char());
		endcase
	endtask

	// long_slot: 1 long key, 2 long string, 3 long number, all in the first pair
	task automatic build_object(input int unsigned n_pairs, input int unsigned long_slot,
			input bit may_cut);
		int unsigned klen;
		int unsigned cut;
		obj_beats.delete();
		add_blanks(1'b0);
		if ($urandom_range(7) != 0) push_ch(CH_LBRACE);
		add_blanks(1'b0);
		for (int i = 0; i < n_pairs; i++) begin
			if (i != 0) begin
				add_blanks(1'b0);
				push_ch(CH_COMMA);
				add_blanks(1'b0);
			end
			push_ch(CH_QUOTE);
			klen = (long_slot == 1 && i == 0) ? $urandom_range(63, 70) : $urandom_range(0, 5);
			repeat (klen) push_ch(text_char());
			push_ch(CH_QUOTE);
			add_blanks(1'b0);
			push_ch(CH_COLON);
			add_blanks(1'b1);
			if (long_slot == 2 && i == 0) add_value(0, 515);
			else if (long_slot == 3 && i == 0) add_value(1, 515);
			else add_value($urandom_range(6), $urandom_range(0, 6));
		end
		add_blanks(1'b0);
		if ($urandom_range(9) != 0) push_ch(CH_RBRACE);
		if ($urandom_range(7) == 0) repeat ($urandom_range(1, 4)) push_ch(8'($urandom_range(255)));
		// end the text early now and then, anywhere inside it
		if (may_cut && $urandom_range(5) == 0) begin
			cut = $urandom_range(obj_beats.size());
			while (obj_beats.size() > cut) void'(obj_beats.pop_back());
		end
		obj_beats.push_back({8'($urandom_range(255)), 1'b1});
	endtask

	task automatic build_noise();
		obj_beats.delete();
		if ($urandom_range(1)) begin
			push_ch(CH_LBRACE);
			push_ch(CH_QUOTE);
		end
		repeat ($urandom_range(1, 24)) push_ch(8'($urandom_range(255)));
		obj_beats.push_back({8'($urandom_range(255)), 1'b1});
	endtask

	task automatic set_idle(input int unsigned n);
		case ((n / 150) % 4)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
			default: begin send_idle_pct = 27; recv_stall_pct = 27; end
		endcase
	endtask

	// drive one text beat, record what it should produce, wait for acceptance
	task automatic put_beat(input text_t t, input logic typed, input token_t tok);
		int unsigned gap;
		bit          has;
		token_t      r;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap != 0) begin
			text_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		parser_step(t, has, r);
		if (typed) pending_tokens.push_back(tok);
		else if (has) pending_tokens.push_back(r);
		text_valid <= 1'b1;
		text_data <= t;
		do @(posedge clk); while (text_stall);
		beats_sent++;
	endtask

	// ---------------- checking ----------------

	task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] g);
		if (e !== g) begin
			errors++;
			if (errors <= MAX_REPORTS)
				$display("%0t: token %0d %s expected %0h got %0h", $time,
					tokens_seen, name, e, g);
		end
	endtask

	// check each token beat, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: token %0d expected none got %h", $time,
						tokens_seen, token_data);
			end else begin
				token_t e;
				e = pending_tokens.pop_front();
				check_field("key_char_valid", 8'(e.key_char_valid),
					8'(token_data.key_char_valid));
				check_field("value_char_valid", 8'(e.value_char_valid),
					8'(token_data.value_char_valid));
				check_field("char_out", e.char_out, token_data.char_out);
				check_field("pair_end", 8'(e.pair_end), 8'(token_data.pair_end));
				check_field("pair_type", 8'(e.pair_type), 8'(token_data.pair_type));
				check_field("pair_index", 8'(e.pair_index), 8'(token_data.pair_index));
				check_field("parse_end", 8'(e.parse_end), 8'(token_data.parse_end));
				check_field("parse_ok", 8'(e.parse_ok), 8'(token_data.parse_ok));
				check_field("pair_total", 8'(e.pair_total), 8'(token_data.pair_total));
			end
			tokens_seen++;
			if (token_data.pair_end) pair_ends_seen++;
			if (token_data.parse_end) texts_closed++;
		end
		token_stall <= arst_n && ($urandom_range(99) < recv_stall_pct);
	end

	// give up on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: no progress after %0d cycles, %0d tokens still due", $time,
				cycle_count, pending_tokens.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------- main sequence ----------------

	initial begin
		int unsigned rand_beats;
		int unsigned text_no;
		rand_beats = 0;
		text_no = 0;
		parser_clear();

		// directed rows: lone end beat, then literals, extreme key bytes, string, broken literal, number
		dir_rows.push_back(drow(8'hff, 1'b1, 1'b1,
			tok_of(1'b0, 1'b0, 8'h00, 1'b0, TYPE_STRING, 5'd0, 1'b1, 1'b0, 6'd0)));
		dir_rows.push_back(drow(CH_LBRACE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(8'h00, 1'b0, 1'b1,
			tok_of(1'b1, 1'b0, 8'h00, 1'b0, TYPE_STRING, 5'd0, 1'b0, 1'b0, 6'd0)));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COLON, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_T, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_R, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_U, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_E, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COMMA, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(8'hff, 1'b0, 1'b1,
			tok_of(1'b1, 1'b0, 8'hff, 1'b0, TYPE_STRING, 5'd1, 1'b0, 1'b0, 6'd1)));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COLON, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_MINUS, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COMMA, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COLON, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_F, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_S, 1'b0, 1'b1,
			tok_of(1'b0, 1'b0, 8'h00, 1'b1, TYPE_BOOL, 5'd2, 1'b0, 1'b0, 6'd3)));
		dir_rows.push_back(drow(CH_COMMA, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_QUOTE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_COLON, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_NINE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(CH_RBRACE, 1'b0, 1'b0, '0));
		dir_rows.push_back(drow(8'h00, 1'b1, 1'b1,
			tok_of(1'b0, 1'b0, 8'h00, 1'b0, TYPE_STRING, 5'd4, 1'b1, 1'b1, 6'd4)));

		// hold reset, then release
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) put_beat(dir_rows[k].beat, dir_rows[k].typed, dir_rows[k].tok);

		// random objects, with the pair limit and both length limits forced early on
		while (rand_beats < RANDOM_BEATS) begin
			text_no++;
			case (text_no)
				2: build_object(33, 0, 1'b0);
				4: build_object(2, 1, 1'b0);
				6: build_object(1, 2, 1'b0);
				8: build_object(2, 3, 1'b0);
				default: begin
					if ($urandom_range(5) == 0) build_noise();
					else build_object($urandom_range(0, 5), 0, 1'b1);
				end
			endcase
			foreach (obj_beats[k]) begin
				set_idle(rand_beats);
				put_beat(obj_beats[k], 1'b0, '0);
				rand_beats++;
			end
		end
		text_valid <= 1'b0;

		// drain
		while (pending_tokens.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d text beats in %0d objects gave %0d token beats, %0d pair ends",
			beats_sent, texts_closed, tokens_seen, pair_ends_seen);
		$display("Summary: %0d field mismatches over %0d cycles", errors, cycle_count);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/fjpt_pkg.sv
sv/fjpt_front.sv
sv/fjpt_queue.sv
sv/fjpt_back.sv
sv/flat_json_pair_tokenizer_unit.sv
dv/testbench.sv
